// ----- rtl/core/rsi_pkg.sv -----
// rsi_pkg.sv: constants, stream field widths and pipeline carry types for
// the ray/sphere intersection core.
// No dependencies; imported by ray_sphere_intersect.
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 152;
    localparam int OUT_W     = 184;

    localparam int CRD_W  = 32;                    // coordinate width
    localparam int DIR_W  = 18;
    localparam int RAD_W  = 31;
    localparam int DIST_W = 31;
    localparam int NRM_W  = 18;

    localparam int B_W   = CRD_W + 1;              // centre minus origin
    localparam int PB_W  = B_W + DIR_W;            // one term of b.dir
    localparam int P_W   = PB_W + 2;               // b.dir, exact
    localparam int SQ_W  = 2 * CRD_W - FRAC_BITS;  // one scaled b_i^2
    localparam int L2_W  = SQ_W + 2;               // |b|^2
    localparam int TC_W  = P_W - FRAC_BITS;        // projection length
    localparam int T_W   = TC_W + 1;
    localparam int PR_W  = DIR_W + CRD_W;          // dir_i * distance
    localparam int SH_W  = PR_W - FRAC_BITS;
    localparam int SUM_W = CRD_W + 3;

    localparam int SQ1_N = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int AM_W  = 30;
    localparam int SQ2_N = AM_W + 1;
    localparam int DIV_Q = FRAC_BITS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS_SQ
    } cfg_reg_t;

    // Carried through the front half (up to the distance)
    typedef struct packed {
        logic                          miss;
        logic [2:0][CRD_W-1:0]         org;
        logic [2:0][DIR_W-1:0]         dir;
        logic [TC_W-1:0]               tc;
    } front_t;

    // Carried through the back half (normal computation)
    typedef struct packed {
        logic                          miss;
        logic [DIST_W-1:0]             hit_dist;
        logic [2:0][CRD_W-1:0]         pos;
        logic [2:0]                    neg;
        logic [2:0][AM_W-1:0]          am;
        logic [SQ2_N-1:0]              len;
    } back_t;

endpackage

// ----- rtl/core/ray_sphere_intersect.sv -----
// ray_sphere_intersect.sv: fully pipelined ray/sphere intersection core.
// Depends on rsi_pkg (widths, register codes, carry structs).
//
// Usage:
//   Rays enter on the s_ channel, one item per ray; every ray yields exactly
//   one result item on the m_ channel, in order. The sphere (centre and
//   squared radius, Q16.16) sits in four registers written over the cfg_
//   channel, which is always ready; write them only while no ray is in flight.
//   Throughput is one ray per cycle while m_tready does not hold the pipe. From
//   acceptance to m_tvalid a ray passes 5 setup stages, a 24-stage square root
//   for the half chord, 6 position/normal stages, a 31-stage square root for the
//   normal length, a 17-stage divider (three lanes) and the output register.
//   All stages advance together; when the receiver holds m_tready low with a
//   result waiting, the whole pipe freezes and s_tready drops, so no item is
//   lost or repeated. Bubbles travel as cleared valid bits.
//   Reset clears all valid bits and the sphere registers (centre at the
//   origin, zero radius). A miss returns hit = 0 and all data zero.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x[31:0], origin_y[63:32], origin_z[95:64], dir_x[113:96],
    // dir_y[131:114], dir_z[149:132], zero fill
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit_distance[30:0], pos_x[62:31], pos_y[94:63], pos_z[126:95],
    // normal_x[144:127], normal_y[162:145], normal_z[180:163], zero fill
    output logic [OUT_W-1:0]     m_tdata,
    // hit
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic adv;

    // ---------------------------------------------------------------- config
    logic [2:0][CRD_W-1:0] cen_reg;
    logic [RAD_W-1:0]      rad_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg    <= '0;
            rad_sq_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:  cen_reg[0]  <= cfg_data;
                REG_CENTER_Y:  cen_reg[1]  <= cfg_data;
                REG_CENTER_Z:  cen_reg[2]  <= cfg_data;
                REG_RADIUS_SQ: rad_sq_reg  <= cfg_data[RAD_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow
    // One advance for the whole pipe: move whenever the output slot is free
    // or being emptied this cycle.
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    // Unpack the ray
    logic [2:0][CRD_W-1:0] in_org;
    logic [2:0][DIR_W-1:0] in_dir;
    assign in_org = s_tdata[3*CRD_W-1:0];
    assign in_dir = s_tdata[3*CRD_W+3*DIR_W-1:3*CRD_W];

    // ---------------------------------------------------------------- S1..S5
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    front_t s1_ctx_reg, s2_ctx_reg, s3_ctx_reg, s4_ctx_reg, s5_ctx_reg;
    front_t s1_ctx_next, s4_ctx_next, s5_ctx_next;

    logic signed [B_W-1:0]  s1_b_next [3];
    logic signed [B_W-1:0]  s1_b_reg  [3];
    logic signed [PB_W-1:0] s2_pb_next [3];
    logic signed [PB_W-1:0] s2_pb_reg  [3];
    logic [B_W-1:0]         s2_bm [3];
    logic [2*CRD_W-1:0]     s2_sq_full [3];
    logic [SQ_W-1:0]        s2_sq_next [3];
    logic [SQ_W-1:0]        s2_sq_reg  [3];
    logic signed [P_W-1:0]  s3_p_next, s3_p_reg;
    logic [L2_W-1:0]        s3_l2_next, s3_l2_reg;
    logic [2*CRD_W-1:0]     s4_t2_full;
    logic [SQ_W-1:0]        s4_t2_next, s4_t2_reg;
    logic                   s4_big_next, s4_big_reg;
    logic [L2_W-1:0]        s4_l2_reg;
    logic [L2_W-1:0]        s5_off;
    logic [RAD_W-1:0]       s5_h_next, s5_h_reg;

    // S1: b = centre - origin
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s1_b_next[i] = $signed({cen_reg[i][CRD_W-1], cen_reg[i]})
                         - $signed({in_org[i][CRD_W-1], in_org[i]});
        s1_ctx_next.miss = 1'b0;
        s1_ctx_next.org  = in_org;
        s1_ctx_next.dir  = in_dir;
        s1_ctx_next.tc   = '0;
    end

    // S2: terms of b.dir and of |b|^2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pb_next[i] = s1_b_reg[i] * $signed(s1_ctx_reg.dir[i]);
            s2_bm[i]      = s1_b_reg[i][B_W-1] ? B_W'(-s1_b_reg[i]) : B_W'(s1_b_reg[i]);
            s2_sq_full[i] = s2_bm[i][CRD_W-1:0] * s2_bm[i][CRD_W-1:0];
            s2_sq_next[i] = s2_sq_full[i][2*CRD_W-1:FRAC_BITS];
        end
    end

    // S3: sums
    always_comb
    begin
        s3_p_next  = P_W'(s2_pb_reg[0]) + P_W'(s2_pb_reg[1]) + P_W'(s2_pb_reg[2]);
        s3_l2_next = L2_W'(s2_sq_reg[0]) + L2_W'(s2_sq_reg[1]) + L2_W'(s2_sq_reg[2]);
    end

    // S4: projection sign, tc and tc^2
    always_comb
    begin
        s4_ctx_next      = s3_ctx_reg;
        s4_ctx_next.miss = s3_p_reg[P_W-1];
        s4_ctx_next.tc   = s3_p_reg[P_W-1:FRAC_BITS];
        s4_big_next      = |s4_ctx_next.tc[TC_W-1:CRD_W];
        s4_t2_full       = s4_ctx_next.tc[CRD_W-1:0] * s4_ctx_next.tc[CRD_W-1:0];
        s4_t2_next       = s4_t2_full[2*CRD_W-1:FRAC_BITS];
    end

    // S5: perpendicular offset against the radius
    always_comb
    begin
        if (s4_big_reg)
            s5_off = '0;
        else if (s4_l2_reg > L2_W'(s4_t2_reg))
            s5_off = s4_l2_reg - L2_W'(s4_t2_reg);
        else
            s5_off = '0;
        s5_ctx_next      = s4_ctx_reg;
        s5_ctx_next.miss = s4_ctx_reg.miss || (s5_off > L2_W'(rad_sq_reg));
        s5_h_next        = rad_sq_reg - s5_off[RAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_b_reg   <= s1_b_next;
            s1_ctx_reg <= s1_ctx_next;
            s2_pb_reg  <= s2_pb_next;
            s2_sq_reg  <= s2_sq_next;
            s2_ctx_reg <= s1_ctx_reg;
            s3_p_reg   <= s3_p_next;
            s3_l2_reg  <= s3_l2_next;
            s3_ctx_reg <= s2_ctx_reg;
            s4_ctx_reg <= s4_ctx_next;
            s4_t2_reg  <= s4_t2_next;
            s4_big_reg <= s4_big_next;
            s4_l2_reg  <= s3_l2_reg;
            s5_ctx_reg <= s5_ctx_next;
            s5_h_reg   <= s5_h_next;
        end
    end

    // ---------------------------------------------------------------- half chord
    // d = floor(sqrt(h << FRAC_BITS)), one root bit per stage
    logic                 sq1_vld_reg  [SQ1_N];
    logic [SQ1_N+1:0]     sq1_rem_reg  [SQ1_N];
    logic [SQ1_N-1:0]     sq1_root_reg [SQ1_N];
    logic [2*SQ1_N-1:0]   sq1_x_reg    [SQ1_N];
    front_t               sq1_ctx_reg  [SQ1_N];

    for (genvar k = 0; k < SQ1_N; k++)
    begin : g_sq1
        logic               vld_in;
        logic [SQ1_N+1:0]   rem_in;
        logic [SQ1_N-1:0]   root_in;
        logic [2*SQ1_N-1:0] x_in;
        front_t             ctx_in;
        logic [SQ1_N+3:0]   cur, trial, rem_next;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = s5_vld_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = (2*SQ1_N)'({s5_h_reg, {FRAC_BITS{1'b0}}});
            assign ctx_in  = s5_ctx_reg;
        end
        else
        begin : g_rest
            assign vld_in  = sq1_vld_reg[k-1];
            assign rem_in  = sq1_rem_reg[k-1];
            assign root_in = sq1_root_reg[k-1];
            assign x_in    = sq1_x_reg[k-1];
            assign ctx_in  = sq1_ctx_reg[k-1];
        end

        assign cur      = {rem_in, x_in[2*SQ1_N-1 -: 2]};
        assign trial    = {2'b00, root_in, 2'b01};
        assign ge       = cur >= trial;
        assign rem_next = ge ? cur - trial : cur;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq1_vld_reg[k] <= 1'b0;
            else if (adv)
                sq1_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq1_rem_reg[k]  <= rem_next[SQ1_N+1:0];
                sq1_root_reg[k] <= {root_in[SQ1_N-2:0], ge};
                sq1_x_reg[k]    <= {x_in[2*SQ1_N-3:0], 2'b00};
                sq1_ctx_reg[k]  <= ctx_in;
            end
        end
    end

    // ---------------------------------------------------------------- S6..S11
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg, s11_vld_reg;
    front_t s6_ctx_reg, s7_ctx_reg;
    back_t  s8_ctx_next, s8_ctx_reg, s9_ctx_next, s9_ctx_reg, s10_ctx_reg, s11_ctx_reg;

    logic [T_W-1:0]          s6_td, s6_ts;
    logic [DIST_W-1:0]       s6_dist_next, s6_dist_reg, s7_dist_reg;
    logic signed [PR_W-1:0]  s7_pr_next [3];
    logic signed [PR_W-1:0]  s7_pr_reg  [3];
    logic [SH_W-1:0]         s8_sh  [3];
    logic [SUM_W-1:0]        s8_sum [3];
    logic [B_W-1:0]          s9_n   [3];
    logic [B_W-1:0]          s9_am  [3];
    logic [B_W-1:0]          s9_amsh [3];
    logic [B_W-1:0]          s9_or;
    logic [1:0]              s9_shift;
    logic [2*AM_W-1:0]       s10_sq_next [3];
    logic [2*AM_W-1:0]       s10_sq_reg  [3];
    logic [2*SQ2_N-1:0]      s11_sum_next, s11_sum_reg;

    // S6: near root, else far root; saturate the distance
    always_comb
    begin
        s6_td = {1'b0, sq1_ctx_reg[SQ1_N-1].tc} - T_W'(sq1_root_reg[SQ1_N-1]);
        if (s6_td[T_W-1])
            s6_ts = {1'b0, sq1_ctx_reg[SQ1_N-1].tc} + T_W'(sq1_root_reg[SQ1_N-1]);
        else
            s6_ts = s6_td;
        s6_dist_next = (|s6_ts[T_W-1:DIST_W]) ? {DIST_W{1'b1}} : s6_ts[DIST_W-1:0];
    end

    // S7: dir * distance
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s7_pr_next[i] = $signed(s6_ctx_reg.dir[i]) * $signed({1'b0, s6_dist_reg});
    end

    // S8: position, saturated to 32 bits
    always_comb
    begin
        s8_ctx_next          = '0;
        s8_ctx_next.miss     = s7_ctx_reg.miss;
        s8_ctx_next.hit_dist = s7_dist_reg;
        for (int i = 0; i < 3; i++)
        begin
            s8_sh[i]  = s7_pr_reg[i][PR_W-1:FRAC_BITS];
            s8_sum[i] = SUM_W'($signed(s7_ctx_reg.org[i])) + SUM_W'($signed(s8_sh[i]));
            if (s8_sum[i][SUM_W-1:CRD_W-1] == '0 || s8_sum[i][SUM_W-1:CRD_W-1] == '1)
                s8_ctx_next.pos[i] = s8_sum[i][CRD_W-1:0];
            else if (s8_sum[i][SUM_W-1])
                s8_ctx_next.pos[i] = {1'b1, {(CRD_W-1){1'b0}}};
            else
                s8_ctx_next.pos[i] = {1'b0, {(CRD_W-1){1'b1}}};
        end
    end

    // S9: normal vector magnitudes, scaled together below 2^30
    always_comb
    begin
        s9_ctx_next = s8_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s9_n[i]  = {s8_ctx_reg.pos[i][CRD_W-1], s8_ctx_reg.pos[i]}
                     - {cen_reg[i][CRD_W-1], cen_reg[i]};
            s9_am[i] = s9_n[i][B_W-1] ? B_W'(-s9_n[i]) : s9_n[i];
            s9_ctx_next.neg[i] = s9_n[i][B_W-1];
        end
        s9_or = s9_am[0] | s9_am[1] | s9_am[2];
        if (s9_or[AM_W+2])
            s9_shift = 2'd3;
        else if (s9_or[AM_W+1])
            s9_shift = 2'd2;
        else if (s9_or[AM_W])
            s9_shift = 2'd1;
        else
            s9_shift = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            s9_amsh[i]        = s9_am[i] >> s9_shift;
            s9_ctx_next.am[i] = s9_amsh[i][AM_W-1:0];
        end
    end

    // S10: squares; S11: their sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s10_sq_next[i] = s9_ctx_reg.am[i] * s9_ctx_reg.am[i];
        s11_sum_next = (2*SQ2_N)'(s10_sq_reg[0]) + (2*SQ2_N)'(s10_sq_reg[1])
                     + (2*SQ2_N)'(s10_sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_vld_reg  <= sq1_vld_reg[SQ1_N-1];
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_ctx_reg   <= sq1_ctx_reg[SQ1_N-1];
            s6_dist_reg  <= s6_dist_next;
            s7_ctx_reg   <= s6_ctx_reg;
            s7_dist_reg  <= s6_dist_reg;
            s7_pr_reg    <= s7_pr_next;
            s8_ctx_reg   <= s8_ctx_next;
            s9_ctx_reg   <= s9_ctx_next;
            s10_ctx_reg  <= s9_ctx_reg;
            s10_sq_reg   <= s10_sq_next;
            s11_ctx_reg  <= s10_ctx_reg;
            s11_sum_reg  <= s11_sum_next;
        end
    end

    // ---------------------------------------------------------------- normal length
    logic                 sq2_vld_reg  [SQ2_N];
    logic [SQ2_N+1:0]     sq2_rem_reg  [SQ2_N];
    logic [SQ2_N-1:0]     sq2_root_reg [SQ2_N];
    logic [2*SQ2_N-1:0]   sq2_x_reg    [SQ2_N];
    back_t                sq2_ctx_reg  [SQ2_N];

    for (genvar k = 0; k < SQ2_N; k++)
    begin : g_sq2
        logic               vld_in;
        logic [SQ2_N+1:0]   rem_in;
        logic [SQ2_N-1:0]   root_in;
        logic [2*SQ2_N-1:0] x_in;
        back_t              ctx_in;
        logic [SQ2_N+3:0]   cur, trial, rem_next;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = s11_vld_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = s11_sum_reg;
            assign ctx_in  = s11_ctx_reg;
        end
        else
        begin : g_rest
            assign vld_in  = sq2_vld_reg[k-1];
            assign rem_in  = sq2_rem_reg[k-1];
            assign root_in = sq2_root_reg[k-1];
            assign x_in    = sq2_x_reg[k-1];
            assign ctx_in  = sq2_ctx_reg[k-1];
        end

        assign cur      = {rem_in, x_in[2*SQ2_N-1 -: 2]};
        assign trial    = {2'b00, root_in, 2'b01};
        assign ge       = cur >= trial;
        assign rem_next = ge ? cur - trial : cur;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq2_vld_reg[k] <= 1'b0;
            else if (adv)
                sq2_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq2_rem_reg[k]  <= rem_next[SQ2_N+1:0];
                sq2_root_reg[k] <= {root_in[SQ2_N-2:0], ge};
                sq2_x_reg[k]    <= {x_in[2*SQ2_N-3:0], 2'b00};
                sq2_ctx_reg[k]  <= ctx_in;
            end
        end
    end

    // ---------------------------------------------------------------- divider
    // q_i = (am_i << FRAC_BITS) / len, restoring, one quotient bit per stage.
    // am_i <= len, so the quotient never exceeds 2^FRAC_BITS.
    logic                 dv_vld_reg [DIV_Q];
    back_t                dv_ctx_reg [DIV_Q];
    logic [SQ2_N-1:0]     dv_rem_reg [3][DIV_Q];
    logic [DIV_Q-1:0]     dv_q_reg   [3][DIV_Q];

    for (genvar k = 0; k < DIV_Q; k++)
    begin : g_div
        logic  vld_in;
        back_t ctx_in;

        if (k == 0)
        begin : g_first
            assign vld_in = sq2_vld_reg[SQ2_N-1];
            always_comb
            begin
                ctx_in     = sq2_ctx_reg[SQ2_N-1];
                ctx_in.len = sq2_root_reg[SQ2_N-1];
            end
        end
        else
        begin : g_rest
            assign vld_in = dv_vld_reg[k-1];
            assign ctx_in = dv_ctx_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k] <= 1'b0;
            else if (adv)
                dv_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_ctx_reg[k] <= ctx_in;
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [SQ2_N-1:0] rem_in;
            logic [DIV_Q-1:0] q_in;
            logic             bit_in;
            logic [SQ2_N:0]   cur, diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_in = SQ2_N'(ctx_in.am[j][AM_W-1:1]);
                assign q_in   = '0;
                assign bit_in = ctx_in.am[j][0];
            end
            else
            begin : g_rest
                assign rem_in = dv_rem_reg[j][k-1];
                assign q_in   = dv_q_reg[j][k-1];
                assign bit_in = 1'b0;
            end

            assign cur  = {rem_in, bit_in};
            assign diff = cur - {1'b0, ctx_in.len};
            assign ge   = cur >= {1'b0, ctx_in.len};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[j][k] <= ge ? diff[SQ2_N-1:0] : cur[SQ2_N-1:0];
                    dv_q_reg[j][k]   <= {q_in[DIV_Q-2:0], ge};
                end
            end
        end
    end

    // ---------------------------------------------------------------- output
    back_t                  out_ctx;
    logic [2:0][NRM_W-1:0]  out_nrm;
    logic [OUT_W-1:0]       m_tdata_next, m_tdata_reg;
    logic                   m_tuser_next, m_tuser_reg;

    // Apply the sign, zero the normal at the centre, zero everything on a miss
    always_comb
    begin
        out_ctx = dv_ctx_reg[DIV_Q-1];
        for (int i = 0; i < 3; i++)
        begin
            if (out_ctx.len == '0)
                out_nrm[i] = '0;
            else if (out_ctx.neg[i])
                out_nrm[i] = NRM_W'(-{1'b0, dv_q_reg[i][DIV_Q-1]});
            else
                out_nrm[i] = {1'b0, dv_q_reg[i][DIV_Q-1]};
        end
        if (out_ctx.miss)
        begin
            m_tdata_next = '0;
            m_tuser_next = 1'b0;
        end
        else
        begin
            m_tdata_next = OUT_W'({out_nrm, out_ctx.pos, out_ctx.hit_dist});
            m_tuser_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= dv_vld_reg[DIV_Q-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    // A miss leaves no stray data behind
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result carries nonzero data");

    // A frozen pipe keeps its valid bits
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_vld_reg) && $stable(sq2_vld_reg[SQ2_N-1])
                 && $stable(dv_vld_reg[DIV_Q-1]))
        else $error("valid bit moved during a stall");

    // Half-chord root is a true floor square root
    a_sq1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq1_vld_reg[SQ1_N-1] |->
            sq1_rem_reg[SQ1_N-1] <= {1'b0, sq1_root_reg[SQ1_N-1], 1'b0})
        else $error("square root remainder out of range");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_Q-1] && dv_ctx_reg[DIV_Q-1].len != '0 |->
            dv_rem_reg[0][DIV_Q-1] < dv_ctx_reg[DIV_Q-1].len)
        else $error("divider remainder not below length");

    // Normal components never exceed one
    a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_Q-1] && dv_ctx_reg[DIV_Q-1].len != '0 |->
            dv_q_reg[0][DIV_Q-1] <= (DIV_Q'(1) << FRAC_BITS)
            && dv_q_reg[1][DIV_Q-1] <= (DIV_Q'(1) << FRAC_BITS)
            && dv_q_reg[2][DIV_Q-1] <= (DIV_Q'(1) << FRAC_BITS))
        else $error("normal component above one");

endmodule
